/* design/tps_pkg.sv */
// shared types, command codes and helpers for the track position seek controller
// no dependencies

package tps_pkg;

  localparam int unsigned STEP_W = 4;

  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_HALL_A     = 3'd1;
  localparam logic [2:0] CMD_HALL_B     = 3'd2;
  localparam logic [2:0] CMD_TARGET     = 3'd3;
  localparam logic [2:0] CMD_DISCONNECT = 3'd4;

  localparam logic [1:0] REG_MIN_DUTY     = 2'd0;
  localparam logic [1:0] REG_MAX_DUTY     = 2'd1;
  localparam logic [1:0] REG_REVERSE_WAIT = 2'd2;
  localparam logic [1:0] REG_STALL_IVL    = 2'd3;

  localparam logic [9:0]  MIN_DUTY_RST     = 10'd512;
  localparam logic [9:0]  MAX_DUTY_RST     = 10'd800;
  localparam logic [15:0] REVERSE_WAIT_RST = 16'd2000;
  localparam logic [15:0] STALL_IVL_RST    = 16'd1000;

  typedef struct packed {
    logic [9:0]  min_duty;
    logic [9:0]  max_duty;
    logic [15:0] reverse_wait_ms;
    logic [15:0] stall_interval_ms;
  } tps_cfg_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        now_ms;
    logic               hall_a_level;
    logic               hall_b_level;
    logic signed [31:0] new_target;
  } tps_item_t;

  typedef struct packed {
    logic               direction_bit;
    logic               over_magnet;
    logic [31:0]        enter_stamp;
    logic [31:0]        dwell_time;
    logic signed [7:0]  pending_delta;
    logic [31:0]        abs_position;
    logic [31:0]        target_position;
    logic [31:0]        prior_position;
    logic [STEP_W-1:0]  speed_step;
    logic               reversing;
    logic [31:0]        reverse_stamp;
    logic [31:0]        speed_stamp;
    logic               report_owed;
    logic [9:0]         pwm_out;
    logic               dir_out;
    logic               led_out;
  } tps_state_t;

  localparam tps_state_t STATE_RST = '{
    direction_bit:   1'b0,
    over_magnet:     1'b0,
    enter_stamp:     32'd0,
    dwell_time:      32'd0,
    pending_delta:   8'sd0,
    abs_position:    32'd0,
    target_position: 32'd0,
    prior_position:  32'd0,
    speed_step:      '0,
    reversing:       1'b0,
    reverse_stamp:   32'd0,
    speed_stamp:     32'd0,
    report_owed:     1'b1,
    pwm_out:         10'd0,
    dir_out:         1'b0,
    led_out:         1'b1
  };

  // saturating one-count move of the pending magnet count
  function automatic logic signed [7:0] pend_bump(input logic signed [7:0] v,
                                                  input logic up);
    logic signed [7:0] r;
    if (up) begin
      r = (v == 8'sd127) ? v : v + 8'sd1;
    end else begin
      r = (v == -8'sd128) ? v : v - 8'sd1;
    end
    return r;
  endfunction

endpackage

/* design/tps_inc.sv */
// per-step duty increment: (max_duty - min_duty) / (SPEED_STEPS - 1), toward zero
// constant divide done as reciprocal multiply, result registered; uses tps_pkg

module tps_inc #(
  parameter int unsigned SPEED_STEPS = 10
) (
  input  logic               clk,
  input  tps_pkg::tps_cfg_t  cfg,
  output logic signed [10:0] inc
);
  import tps_pkg::*;

  localparam int unsigned Div   = SPEED_STEPS - 1;
  localparam int unsigned Shift = 20;
  // ceiling reciprocal, exact for any 10-bit magnitude with divisors below 15
  localparam int unsigned Recip = ((1 << Shift) + Div - 1) / Div;

  logic signed [10:0] diff;
  logic [9:0]         mag;
  logic [30:0]        prod;
  logic [9:0]         quo;

  always_comb begin
    diff = $signed({1'b0, cfg.max_duty}) - $signed({1'b0, cfg.min_duty});
    mag  = diff[10] ? 10'(-diff) : diff[9:0];
    prod = 31'({21'b0, mag} * 31'(Recip));
    quo  = prod[Shift +: 10];
  end

  always_ff @(posedge clk) begin
    inc <= diff[10] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

endmodule

/* design/tps_step.sv */
// next-state and result logic for one item of the seek controller
// purely combinational; uses tps_pkg

module tps_step #(
  parameter int unsigned SPEED_STEPS = 10
) (
  input  tps_pkg::tps_state_t cur,
  input  tps_pkg::tps_item_t  item,
  input  tps_pkg::tps_cfg_t   cfg,
  input  logic signed [10:0]  inc,
  output tps_pkg::tps_state_t nxt,
  output logic                report_valid
);
  import tps_pkg::*;

  localparam logic [STEP_W-1:0] TopStep = STEP_W'(SPEED_STEPS);

  tps_state_t         s;
  logic               hold;
  logic               moved;
  logic               stalled;
  logic [31:0]        rev_elapsed;
  logic [31:0]        spd_elapsed;
  logic signed [32:0] pos;
  logic signed [32:0] goal;
  logic signed [32:0] remain;

  function automatic logic [9:0] duty_of(input logic [STEP_W-1:0] st);
    logic signed [15:0] acc;
    logic [9:0]         d;
    acc = $signed({6'b0, cfg.min_duty}) +
          $signed({12'b0, st - STEP_W'(1)}) * $signed({{5{inc[10]}}, inc});
    if (st == '0) begin
      d = 10'd0;
    end else if (st >= TopStep) begin
      d = cfg.max_duty;
    end else begin
      d = acc[9:0];
    end
    return d;
  endfunction

  always_comb begin
    s            = cur;
    report_valid = 1'b0;
    hold         = 1'b0;
    moved        = 1'b0;
    stalled      = 1'b0;
    rev_elapsed  = item.now_ms - cur.reverse_stamp;
    spd_elapsed  = item.now_ms - cur.speed_stamp;
    pos          = '0;
    goal         = '0;
    remain       = '0;

    unique case (item.command)
      CMD_TICK: begin
        s.led_out = ~cur.over_magnet;
        if (cur.pending_delta != 8'sd0) begin
          s.abs_position  = cur.abs_position + 32'($signed(cur.pending_delta));
          s.pending_delta = 8'sd0;
          s.report_owed   = 1'b1;
        end
        if (s.report_owed) begin
          report_valid  = 1'b1;
          s.report_owed = 1'b0;
        end

        // end of reversal wait: flip and re-read the hall sensors
        if (cur.reversing) begin
          if (rev_elapsed < {16'b0, cfg.reverse_wait_ms}) begin
            hold = 1'b1;
          end else begin
            s.reversing     = 1'b0;
            s.direction_bit = ~cur.direction_bit;
            if (!cur.direction_bit) begin
              if (cur.over_magnet) begin
                if (!item.hall_a_level) s.over_magnet = 1'b0;
                else s.pending_delta = pend_bump(s.pending_delta, 1'b1);
              end else if (!item.hall_a_level) begin
                if (!item.hall_b_level) s.pending_delta = pend_bump(s.pending_delta, 1'b0);
                else s.over_magnet = 1'b1;
              end
            end else begin
              if (cur.over_magnet) begin
                if (!item.hall_b_level) s.over_magnet = 1'b0;
                else s.pending_delta = pend_bump(s.pending_delta, 1'b0);
              end else if (!item.hall_a_level) begin
                if (!item.hall_b_level) s.pending_delta = pend_bump(s.pending_delta, 1'b1);
                else s.over_magnet = 1'b1;
              end
            end
          end
        end

        if (!hold) begin
          stalled = spd_elapsed > {16'b0, cfg.stall_interval_ms};
          moved   = s.abs_position != cur.prior_position;
          pos     = {s.abs_position[31], s.abs_position};
          goal    = {cur.target_position[31], cur.target_position};
          remain  = s.direction_bit ? pos - goal : goal - pos;
          if (stalled || moved) begin
            if (cur.speed_step == '0 &&
                ((goal > pos && s.direction_bit) || (goal < pos && !s.direction_bit))) begin
              s.reversing     = 1'b1;
              s.reverse_stamp = item.now_ms;
            end else if (goal == pos) begin
              s.speed_step     = '0;
              s.prior_position = s.abs_position;
            end else begin
              s.speed_stamp = item.now_ms;
              if (!moved || remain > $signed({29'b0, cur.speed_step})) begin
                if (cur.speed_step < TopStep) s.speed_step = cur.speed_step + STEP_W'(1);
              end else begin
                s.speed_step = (cur.speed_step <= STEP_W'(1)) ? STEP_W'(1)
                                                               : cur.speed_step - STEP_W'(1);
              end
              if (moved) s.prior_position = s.abs_position;
            end
          end
          s.pwm_out = duty_of(s.speed_step);
          s.dir_out = s.direction_bit;
        end
      end
      CMD_HALL_A: begin
        if (!cur.direction_bit && !cur.over_magnet) begin
          s.over_magnet = 1'b1;
          s.enter_stamp = item.now_ms;
        end else if (cur.direction_bit && cur.over_magnet) begin
          s.over_magnet   = 1'b0;
          s.dwell_time    = item.now_ms - cur.enter_stamp;
          s.pending_delta = pend_bump(cur.pending_delta, 1'b0);
        end
      end
      CMD_HALL_B: begin
        if (cur.direction_bit && !cur.over_magnet) begin
          s.over_magnet = 1'b1;
          s.enter_stamp = item.now_ms;
        end else if (!cur.direction_bit && cur.over_magnet) begin
          s.over_magnet   = 1'b0;
          s.dwell_time    = item.now_ms - cur.enter_stamp;
          s.pending_delta = pend_bump(cur.pending_delta, 1'b1);
        end
      end
      CMD_TARGET: begin
        s.target_position = item.new_target;
      end
      CMD_DISCONNECT: begin
        s.speed_step = '0;
        s.pwm_out    = 10'd0;
        s.dir_out    = cur.direction_bit;
      end
      default: begin
      end
    endcase

    nxt = s;
  end

endmodule

/* design/track_position_seek_controller_top.sv */
// top level of the track position seek controller: config registers, input and
// result registers around the step logic; uses tps_pkg, tps_inc, tps_step
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------------
//  input     | in_valid / in_stall   | command, now_ms, hall_a_level, hall_b_level,
//            |                       | new_target
//  result    | out_valid / out_stall | pwm_duty, motor_direction, led_level, position,
//            |                       | magnet_dwell_ms, report_valid
//  config    | cfg_we                | cfg_index, cfg_data
//
// one item per cycle unless a stalled result holds the flow; each item waits in the
// input register and its result is then written to the result register
// the step logic between the two registers is combinational
// rst is synchronous; in_stall is held high during reset
// a stalled result keeps its register; the input register still takes one more item

module track_position_seek_controller_top #(
  parameter int unsigned SPEED_STEPS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic [31:0]        now_ms,
  input  logic               hall_a_level,
  input  logic               hall_b_level,
  input  logic signed [31:0] new_target,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         pwm_duty,
  output logic               motor_direction,
  output logic               led_level,
  output logic signed [31:0] position,
  output logic [31:0]        magnet_dwell_ms,
  output logic               report_valid,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import tps_pkg::*;

  tps_cfg_t           cfg;
  tps_item_t          item;
  logic               item_v;
  tps_state_t         st;
  tps_state_t         st_next;
  logic               report_next;
  logic signed [10:0] inc;
  logic               consume;
  logic               accept;

  assign consume  = item_v && (!out_valid || !out_stall);
  assign in_stall = rst || (item_v && !consume);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_duty          <= MIN_DUTY_RST;
      cfg.max_duty          <= MAX_DUTY_RST;
      cfg.reverse_wait_ms   <= REVERSE_WAIT_RST;
      cfg.stall_interval_ms <= STALL_IVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_DUTY:     cfg.min_duty          <= cfg_data[9:0];
        REG_MAX_DUTY:     cfg.max_duty          <= cfg_data[9:0];
        REG_REVERSE_WAIT: cfg.reverse_wait_ms   <= cfg_data;
        REG_STALL_IVL:    cfg.stall_interval_ms <= cfg_data;
      endcase
    end
  end

  tps_inc #(.SPEED_STEPS(SPEED_STEPS)) u_inc (
    .clk (clk),
    .cfg (cfg),
    .inc (inc)
  );

  tps_step #(.SPEED_STEPS(SPEED_STEPS)) u_step (
    .cur          (st),
    .item         (item),
    .cfg          (cfg),
    .inc          (inc),
    .nxt          (st_next),
    .report_valid (report_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (accept) begin
      item_v <= 1'b1;
    end else if (consume) begin
      item_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.command      <= command;
      item.now_ms       <= now_ms;
      item.hall_a_level <= hall_a_level;
      item.hall_b_level <= hall_b_level;
      item.new_target   <= new_target;
    end
  end

  // controller state advances once per item, together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RST;
    end else if (consume) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      pwm_duty        <= st_next.pwm_out;
      motor_direction <= st_next.dir_out;
      led_level       <= st_next.led_out;
      position        <= $signed(st_next.abs_position);
      magnet_dwell_ms <= st_next.dwell_time;
      report_valid    <= report_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    st.speed_step <= STEP_W'(SPEED_STEPS))
    else $error("speed step above top step");

  a_reverse_idle: assert property (@(posedge clk) disable iff (rst)
    st.reversing |-> (st.speed_step == '0 && st.pwm_out == 10'd0))
    else $error("motor driven during reversal wait");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !consume)
    else $error("stalled result overwritten");

  a_report_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_valid) |-> !st.report_owed)
    else $error("report still owed after a reported transfer");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (item_v && !consume) |=> (item_v && $stable(item)))
    else $error("waiting input item lost");

endmodule
